// ----- design/ttlp_pkg.sv -----
package ttlp_pkg;

    localparam int unsigned TTL_W    = 31;
    localparam int unsigned ACC_W    = 32;
    localparam int unsigned POS_W    = 16;
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned DIGIT_W  = 4;
    localparam int unsigned FACTOR_W = 20;

    localparam logic [TTL_W-1:0] DEFAULT_TTL_RESET = 31'd3600;
    localparam logic [POS_W-1:0] POS_MAX           = 16'hFFFF;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CHAR_W-1:0] CH_UP_S  = 8'h53;
    localparam logic [CHAR_W-1:0] CH_LO_S  = 8'h73;
    localparam logic [CHAR_W-1:0] CH_UP_M  = 8'h4D;
    localparam logic [CHAR_W-1:0] CH_LO_M  = 8'h6D;
    localparam logic [CHAR_W-1:0] CH_UP_H  = 8'h48;
    localparam logic [CHAR_W-1:0] CH_LO_H  = 8'h68;
    localparam logic [CHAR_W-1:0] CH_UP_D  = 8'h44;
    localparam logic [CHAR_W-1:0] CH_LO_D  = 8'h64;
    localparam logic [CHAR_W-1:0] CH_UP_W  = 8'h57;
    localparam logic [CHAR_W-1:0] CH_LO_W  = 8'h77;

    localparam logic [FACTOR_W-1:0] SECS_PER_SEC  = 20'd1;
    localparam logic [FACTOR_W-1:0] SECS_PER_MIN  = 20'd60;
    localparam logic [FACTOR_W-1:0] SECS_PER_HOUR = 20'd60 * 20'd60;
    localparam logic [FACTOR_W-1:0] SECS_PER_DAY  = 20'd60 * 20'd60 * 20'd24;
    localparam logic [FACTOR_W-1:0] SECS_PER_WEEK = 20'd60 * 20'd60 * 20'd24 * 20'd7;

    typedef struct packed {
        logic                is_nul;
        logic                is_space;
        logic                is_digit;
        logic                is_unit;
        logic [DIGIT_W-1:0]  digit;
        logic [FACTOR_W-1:0] factor;
    } t_char_class;

    typedef struct packed {
        logic             stop;
        logic             early;
        logic [TTL_W-1:0] ttl;
        logic [POS_W-1:0] offset;
    } t_result;

endpackage

// ----- design/ttl_duration_parser_core.sv -----
// Parses a DNS time-to-live text such as "1h30m" into seconds, one byte per
// request, and a new byte may be accepted in every cycle. Digits build a
// number, the unit letters s, m, h, d and w (either case) scale it into the
// total, spaces and tabs are skipped, and a NUL or any other byte ends the
// text with one result: the total (or the configured default when the
// 32-bit total has its top bit set), whether the stop was on a non-NUL byte,
// and the offset of the stopping byte. After such an early stop, bytes are
// dropped up to and including the next NUL. A byte is parsed while it sits
// in the input register and the result register loads at the next edge;
// the accumulator and total update, with its one multiplier, sets the rate
// of one byte per cycle. Input is stalled only while a result is held by a
// stalled output.
module ttl_duration_parser_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [ttlp_pkg::CHAR_W-1:0] i_char_code,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [ttlp_pkg::TTL_W-1:0]  o_ttl_seconds,
    output logic                        o_stopped_early,
    output logic [ttlp_pkg::POS_W-1:0]  o_stop_offset,
    input  logic                        i_cfg_wr_en,
    input  logic [ttlp_pkg::TTL_W-1:0]  i_cfg_wr_data
);
    import ttlp_pkg::*;

    logic              r_in_valid;
    logic [CHAR_W-1:0] r_in_char;
    logic [TTL_W-1:0]  r_default_ttl;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_en;
    t_char_class       w_class;
    t_result           w_res;
    logic              w_discarding;

    // The whole pipe moves unless a finished result is being held.
    assign w_en       = !(r_out_valid && i_out_stall);
    assign o_in_stall = !w_en;

    ttlp_classify u_classify (
        .i_char  (r_in_char),
        .o_class (w_class)
    );

    ttlp_parse u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (w_en && r_in_valid),
        .i_class       (w_class),
        .i_default_ttl (r_default_ttl),
        .o_res         (w_res),
        .o_discarding  (w_discarding)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_default_ttl <= DEFAULT_TTL_RESET;
        end else begin
            if (i_cfg_wr_en) begin
                r_default_ttl <= i_cfg_wr_data;
            end
            if (w_en) begin
                r_in_valid  <= i_in_valid;
                r_out_valid <= r_in_valid && w_res.stop;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_char <= i_char_code;
            if (r_in_valid && w_res.stop) begin
                r_out <= w_res;
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_ttl_seconds   = r_out.ttl;
    assign o_stopped_early = r_out.early;
    assign o_stop_offset   = r_out.offset;

    a_stall_only_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled without a held result");

    a_no_result_while_discarding : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_in_valid && w_discarding) |=> !o_out_valid)
        else $error("result produced while discarding the rest of a text");

    a_no_result_from_bubble : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && !r_in_valid) |=> !o_out_valid)
        else $error("result produced without a request");

    a_nul_stop_not_early : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_in_valid && !w_discarding && r_in_char == CH_NUL)
            |=> (o_out_valid && !o_stopped_early))
        else $error("end of text not reported as a normal stop");

endmodule

// ----- design/ttlp_classify.sv -----
module ttlp_classify (
    input  logic [ttlp_pkg::CHAR_W-1:0] i_char,
    output ttlp_pkg::t_char_class       o_class
);
    import ttlp_pkg::*;

    logic [CHAR_W-1:0] w_off;

    assign w_off = i_char - CH_ZERO;

    always_comb begin
        o_class          = '0;
        o_class.is_nul   = (i_char == CH_NUL);
        o_class.is_space = (i_char == CH_SPACE) || (i_char == CH_TAB);
        o_class.is_digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
        o_class.digit    = w_off[DIGIT_W-1:0];
        o_class.is_unit  = 1'b1;
        unique case (i_char)
            CH_LO_S, CH_UP_S: o_class.factor = SECS_PER_SEC;
            CH_LO_M, CH_UP_M: o_class.factor = SECS_PER_MIN;
            CH_LO_H, CH_UP_H: o_class.factor = SECS_PER_HOUR;
            CH_LO_D, CH_UP_D: o_class.factor = SECS_PER_DAY;
            CH_LO_W, CH_UP_W: o_class.factor = SECS_PER_WEEK;
            default: begin
                o_class.is_unit = 1'b0;
                o_class.factor  = '0;
            end
        endcase
    end

endmodule

// ----- design/ttlp_parse.sv -----
module ttlp_parse (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_step,
    input  ttlp_pkg::t_char_class      i_class,
    input  logic [ttlp_pkg::TTL_W-1:0] i_default_ttl,
    output ttlp_pkg::t_result          o_res,
    output logic                       o_discarding
);
    import ttlp_pkg::*;

    logic [ACC_W-1:0] r_acc, n_acc;
    logic [ACC_W-1:0] r_total, n_total;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_discard, n_discard;
    logic [ACC_W-1:0] w_product;
    logic [ACC_W-1:0] w_final;
    logic             w_stop;

    assign w_product = r_acc * {{(ACC_W-FACTOR_W){1'b0}}, i_class.factor};
    assign w_final   = r_total + r_acc;
    assign w_stop    = !i_class.is_space && !i_class.is_digit && !i_class.is_unit;

    always_comb begin
        n_acc     = r_acc;
        n_total   = r_total;
        n_pos     = r_pos;
        n_discard = r_discard;
        o_res       = '0;
        o_res.ttl   = w_final[ACC_W-1] ? i_default_ttl : w_final[TTL_W-1:0];
        o_res.early = !i_class.is_nul;
        o_res.offset = r_pos;
        if (i_step) begin
            if (r_discard) begin
                if (i_class.is_nul) begin
                    n_discard = 1'b0;
                end
            end else begin
                if (r_pos != POS_MAX) begin
                    n_pos = r_pos + 1'b1;
                end
                if (i_class.is_digit) begin
                    n_acc = (r_acc << 3) + (r_acc << 1)
                          + {{(ACC_W-DIGIT_W){1'b0}}, i_class.digit};
                end else if (i_class.is_unit) begin
                    n_total = r_total + w_product;
                    n_acc   = '0;
                end else if (w_stop) begin
                    o_res.stop = 1'b1;
                    n_acc      = '0;
                    n_total    = '0;
                    n_pos      = '0;
                    n_discard  = !i_class.is_nul;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_total   <= '0;
            r_pos     <= '0;
            r_discard <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_total   <= n_total;
            r_pos     <= n_pos;
            r_discard <= n_discard;
        end
    end

    assign o_discarding = r_discard;

endmodule
